[sv/pipq_pkg.sv]
// package: shared codes and controller/datapath handshake structures
`timescale 1ns / 1ps

package pipq_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // memory read address selects
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_TOP  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       in_ready;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       inc_idx;
    logic       dec_idx;
    logic       idx_from_count;
    logic       wr_shift;
    logic       wr_place;
    logic       pop;
    logic       set_dup;
    logic       set_full;
    logic       load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_fire;
    logic in_action;
    logic idx_eq_count;
    logic idx_zero;
    logic count_zero;
    logic count_full;
    logic vec_match;
    logic lvl_greater;
    logic top_above_mask;
    logic out_busy;
  } stat_t;

endpackage

[sv/pipq_if.sv]
// interfaces: request and response channels
`timescale 1ns / 1ps

interface pipq_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  vector;
  logic [3:0]  level;
  logic [3:0]  mask_level;
  logic [31:0] vector_base;

  modport source (output valid, action, vector, level, mask_level, vector_base,
                  input ready);
  modport sink (input valid, action, vector, level, mask_level, vector_base,
                output ready);
endinterface

interface pipq_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  taken_vector;
  logic [3:0]  new_mask;
  logic [31:0] handler_address;
  logic [1:0]  status;
  logic [5:0]  pending_count;

  modport source (output valid, accepted, taken_vector, new_mask, handler_address,
                  status, pending_count, input ready);
  modport sink (input valid, accepted, taken_vector, new_mask, handler_address,
                status, pending_count, output ready);
endinterface

[sv/pipq_datapath.sv]
// datapath: entry memory, count, pointer, item and result registers
`timescale 1ns / 1ps

module pipq_datapath
  import pipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  pipq_req_if.sink    req,
  pipq_rsp_if.source  rsp,
  input  cmd_t        cmd,
  output stat_t       stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // entry: level in high bits, vector in low bits
  logic [11:0] mem [QUEUE_DEPTH];
  logic [11:0] rd_data;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_prev;
  logic [CW-1:0] count_prev;
  logic [AW-1:0] rd_addr;

  logic [7:0]  item_vector;
  logic [3:0]  item_level;
  logic [3:0]  item_mask;
  logic [31:0] item_base;
  logic        take;
  logic [1:0]  res_status;

  logic        out_valid;
  logic        in_fire;

  assign in_fire    = req.valid && cmd.in_ready;
  assign req.ready  = cmd.in_ready;
  assign idx_prev   = idx - CW'(1);
  assign count_prev = count - CW'(1);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = idx_prev[AW-1:0];
      RD_TOP:  rd_addr = count_prev[AW-1:0];
      default: rd_addr = idx[AW-1:0];
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[idx[AW-1:0]] <= rd_data;
    end else if (cmd.wr_place) begin
      mem[idx[AW-1:0]] <= {item_level, item_vector};
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_vector <= req.vector;
      item_level  <= req.level;
      item_mask   <= req.mask_level;
      item_base   <= req.vector_base;
    end
  end

  // count, pointer and outcome flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      take       <= 1'b0;
      res_status <= STATUS_OK;
    end else begin
      if (in_fire) begin
        idx        <= '0;
        take       <= 1'b0;
        res_status <= STATUS_OK;
      end else if (cmd.idx_from_count) begin
        idx <= count;
      end else if (cmd.inc_idx) begin
        idx <= idx + CW'(1);
      end else if (cmd.dec_idx) begin
        idx <= idx_prev;
      end
      if (cmd.set_dup) begin
        res_status <= STATUS_DUPLICATE;
      end else if (cmd.set_full) begin
        res_status <= STATUS_FULL;
      end
      if (cmd.wr_place) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count_prev;
        take  <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.accepted        <= take;
      rsp.taken_vector    <= take ? rd_data[7:0] : 8'd0;
      rsp.new_mask        <= take ? rd_data[11:8] : item_mask;
      rsp.handler_address <= take ? item_base + {22'd0, rd_data[7:0], 2'b00} : 32'd0;
      rsp.status          <= res_status;
      rsp.pending_count   <= 6'(count);
    end
  end

  assign rsp.valid = out_valid;

  // status towards controller
  always_comb begin
    stat.in_fire        = in_fire;
    stat.in_action      = req.action;
    stat.idx_eq_count   = (idx == count);
    stat.idx_zero       = (idx == '0);
    stat.count_zero     = (count == '0);
    stat.count_full     = (count == CW'(QUEUE_DEPTH));
    stat.vec_match      = (rd_data[7:0] == item_vector);
    stat.lvl_greater    = (rd_data[11:8] > item_level);
    stat.top_above_mask = (rd_data[11:8] > item_mask);
    stat.out_busy       = out_valid && !rsp.ready;
  end

endmodule

[sv/pipq_ctrl.sv]
// controller: state machine sequencing scan, insertion and service
`timescale 1ns / 1ps

module pipq_ctrl
  import pipq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN      = 4'd1;
  localparam logic [3:0] S_SCAN_CHK  = 4'd2;
  localparam logic [3:0] S_SHIFT     = 4'd3;
  localparam logic [3:0] S_SHIFT_CHK = 4'd4;
  localparam logic [3:0] S_PLACE     = 4'd5;
  localparam logic [3:0] S_SRV       = 4'd6;
  localparam logic [3:0] S_SRV_CHK   = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_fire) begin
          state_next = stat.in_action ? S_SRV : S_SCAN;
        end
      end
      // duplicate search over the pending entries
      S_SCAN: begin
        if (stat.idx_eq_count) begin
          if (stat.count_full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.idx_from_count = 1'b1;
            state_next         = S_SHIFT;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.vec_match) begin
          cmd.set_dup = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      // move higher-level entries up one place
      S_SHIFT: begin
        if (stat.idx_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_SHIFT_CHK;
        end
      end
      S_SHIFT_CHK: begin
        if (stat.lvl_greater) begin
          cmd.wr_shift = 1'b1;
          cmd.dec_idx  = 1'b1;
          state_next   = S_SHIFT;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_place = 1'b1;
        state_next   = S_FINISH;
      end
      // service check against the top entry
      S_SRV: begin
        if (stat.count_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP;
          state_next = S_SRV_CHK;
        end
      end
      S_SRV_CHK: begin
        if (stat.top_above_mask) begin
          cmd.pop = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/pending_interrupt_priority_queue.sv]
// top level: pending interrupt priority queue
`timescale 1ns / 1ps

// Holds up to QUEUE_DEPTH pending interrupts sorted by ascending level in a
// single-port entry memory; equal levels are served latest arrival first. One
// request transaction is worked on at a time and gives exactly one response
// transaction, held in an output register so the next request can be taken
// while the response waits. A service check reads the top entry and pops it
// when its level is above the mask level; on an empty queue it skips the read.
// A raise compares every pending entry in the duplicate search, then shifts
// higher-level entries up one place and writes the new entry; a duplicate
// ends the search at the matching entry, a full queue ends it after the search.
// A response still held in the output register delays the end of a request.
// Each comparison in the search and shift loops waits for the registered
// memory read. No clearing pass is needed after reset.
module pending_interrupt_priority_queue
  import pipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  pipq_req_if.sink    req,
  pipq_rsp_if.source  rsp
);

  cmd_t  cmd;
  stat_t stat;

  pipq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pipq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
